/* rtl/dbq_pkg.sv */
// package for the blocking double-ended queue
// holds sizes, operation and status codes, kind codes and the item structs
`timescale 1ns / 1ps

package dbq_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int OP_W  = 3;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;
	localparam int EC_W  = 7;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_COUNT      = 3'd4;
	localparam logic [OP_W-1:0] OP_FLUSH      = 3'd5;
	localparam logic [OP_W-1:0] OP_WAKE       = 3'd6;

	localparam logic [ST_W-1:0] STAT_PUSHED       = 3'd0;
	localparam logic [ST_W-1:0] STAT_POPPED       = 3'd1;
	localparam logic [ST_W-1:0] STAT_WOKEN_NULL   = 3'd2;
	localparam logic [ST_W-1:0] STAT_FULL_DROPPED = 3'd3;
	localparam logic [ST_W-1:0] STAT_COUNT        = 3'd4;
	localparam logic [ST_W-1:0] STAT_FLUSHED      = 3'd5;

	// command kinds handed from the front part to the back part
	localparam logic [2:0] KIND_PUSH  = 3'd0;
	localparam logic [2:0] KIND_POP   = 3'd1;
	localparam logic [2:0] KIND_COUNT = 3'd2;
	localparam logic [2:0] KIND_FLUSH = 3'd3;
	localparam logic [2:0] KIND_WAKE  = 3'd4;
	localparam logic [2:0] KIND_NONE  = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [VAL_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value_out;
		logic [ST_W-1:0]  status;
		logic [EC_W-1:0]  entry_count;
	} out_item_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic              at_back;
		logic [DATA_W-1:0] word;
	} cmd_t;

endpackage

/* rtl/dbq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read data holds until the next read
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/dbq_cmd_fifo.sv */
// two-entry command queue between the front and back parts
// depends on dbq_pkg
`timescale 1ns / 1ps

module dbq_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  dbq_pkg::cmd_t wr_cmd,
	output logic          rd_valid,
	input  logic          rd_ready,
	output dbq_pkg::cmd_t rd_cmd
);

	dbq_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          push;
	logic          pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

/* rtl/dbq_front.sv */
// front part: accepts items and sorts them into command kinds
// depends on dbq_pkg
`timescale 1ns / 1ps

module dbq_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  dbq_pkg::in_item_t in_item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output dbq_pkg::cmd_t     cmd
);

	logic [2:0] kind;

	always_comb begin
		case (in_item.operation)
			dbq_pkg::OP_PUSH_FRONT, dbq_pkg::OP_PUSH_BACK: kind = dbq_pkg::KIND_PUSH;
			dbq_pkg::OP_POP_FRONT, dbq_pkg::OP_POP_BACK:   kind = dbq_pkg::KIND_POP;
			dbq_pkg::OP_COUNT:                             kind = dbq_pkg::KIND_COUNT;
			dbq_pkg::OP_FLUSH:                             kind = dbq_pkg::KIND_FLUSH;
			dbq_pkg::OP_WAKE:                              kind = dbq_pkg::KIND_WAKE;
			default:                                       kind = dbq_pkg::KIND_NONE;
		endcase
	end

	// unused codes are taken and dropped here
	assign in_ready    = cmd_ready;
	assign cmd_valid   = in_valid && (kind != dbq_pkg::KIND_NONE);
	assign cmd.kind    = kind;
	assign cmd.at_back = (in_item.operation == dbq_pkg::OP_PUSH_BACK) ||
		(in_item.operation == dbq_pkg::OP_POP_BACK);
	assign cmd.word    = in_item.item_value[dbq_pkg::DATA_W-1:0];

endmodule

/* rtl/dbq_back.sv */
// back part: ring pointers, count, wait and wake marks, ring ram and output register
// depends on dbq_pkg and dbq_ram
`timescale 1ns / 1ps

module dbq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  dbq_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output dbq_pkg::out_item_t out_item
);

	localparam logic BK_IDLE = 1'b0;
	localparam logic BK_READ = 1'b1;

	logic                       state_q;
	logic [dbq_pkg::ADDR_W-1:0] front_q;
	logic [dbq_pkg::ADDR_W-1:0] back_q;
	logic [dbq_pkg::CNT_W-1:0]  count_q;
	logic                       woken_q;
	logic                       waiting_q;
	logic                       out_valid_q;
	dbq_pkg::out_item_t         out_q;

	logic                       out_free;
	logic                       exec;
	logic                       empty;
	logic                       full;
	logic [dbq_pkg::ADDR_W-1:0] front_prev;
	logic [dbq_pkg::ADDR_W-1:0] front_next;
	logic [dbq_pkg::ADDR_W-1:0] back_prev;
	logic [dbq_pkg::ADDR_W-1:0] back_next;
	logic                       wr_en;
	logic [dbq_pkg::ADDR_W-1:0] wr_addr;
	logic                       rd_en;
	logic [dbq_pkg::ADDR_W-1:0] rd_addr;
	logic [dbq_pkg::DATA_W-1:0] rd_data;
	logic                       res_load;
	dbq_pkg::out_item_t         res_item;

	function automatic logic [dbq_pkg::ADDR_W-1:0] idx_next(
		input logic [dbq_pkg::ADDR_W-1:0] i);
		return (i == dbq_pkg::ADDR_W'(dbq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [dbq_pkg::ADDR_W-1:0] idx_prev(
		input logic [dbq_pkg::ADDR_W-1:0] i);
		return (i == '0) ? dbq_pkg::ADDR_W'(dbq_pkg::DEPTH - 1) : i - 1'b1;
	endfunction

	assign out_free   = !out_valid_q || out_ready;
	assign cmd_ready  = (state_q == BK_IDLE) && out_free;
	assign exec       = cmd_valid && cmd_ready;
	assign empty      = (count_q == '0);
	assign full       = (count_q == dbq_pkg::CNT_W'(dbq_pkg::DEPTH));
	assign front_prev = idx_prev(front_q);
	assign front_next = idx_next(front_q);
	assign back_prev  = idx_prev(back_q);
	assign back_next  = idx_next(back_q);

	assign wr_en   = exec && (cmd.kind == dbq_pkg::KIND_PUSH) && !waiting_q && !full;
	assign wr_addr = cmd.at_back ? back_q : front_prev;
	assign rd_en   = exec && (cmd.kind == dbq_pkg::KIND_POP) && !empty;
	assign rd_addr = cmd.at_back ? back_prev : front_q;

	dbq_ram #(
		.WIDTH (dbq_pkg::DATA_W),
		.DEPTH (dbq_pkg::DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		res_load             = 1'b0;
		res_item.value_out   = '0;
		res_item.status      = dbq_pkg::STAT_COUNT;
		res_item.entry_count = dbq_pkg::EC_W'(count_q);
		if (state_q == BK_READ) begin
			// popped word arrives in the cycle after the ram read
			res_load           = out_free;
			res_item.value_out = dbq_pkg::VAL_W'(rd_data);
			res_item.status    = dbq_pkg::STAT_POPPED;
		end else if (exec) begin
			case (cmd.kind)
				dbq_pkg::KIND_PUSH: begin
					res_load = 1'b1;
					if (waiting_q) begin
						res_item.value_out = dbq_pkg::VAL_W'(cmd.word);
						res_item.status    = dbq_pkg::STAT_POPPED;
					end else if (full) begin
						res_item.status = dbq_pkg::STAT_FULL_DROPPED;
					end else begin
						res_item.status      = dbq_pkg::STAT_PUSHED;
						res_item.entry_count = dbq_pkg::EC_W'(count_q + 1'b1);
					end
				end
				dbq_pkg::KIND_POP: begin
					res_load        = empty && woken_q;
					res_item.status = dbq_pkg::STAT_WOKEN_NULL;
				end
				dbq_pkg::KIND_COUNT: begin
					res_load = 1'b1;
				end
				dbq_pkg::KIND_FLUSH: begin
					res_load             = 1'b1;
					res_item.status      = dbq_pkg::STAT_FLUSHED;
					res_item.entry_count = '0;
				end
				dbq_pkg::KIND_WAKE: begin
					res_load        = waiting_q;
					res_item.status = dbq_pkg::STAT_WOKEN_NULL;
				end
				default: begin
					res_load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			woken_q     <= 1'b0;
			waiting_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BK_READ) begin
				if (out_free) begin
					state_q <= BK_IDLE;
				end
			end else if (exec) begin
				case (cmd.kind)
					dbq_pkg::KIND_PUSH: begin
						woken_q <= 1'b0;
						if (waiting_q) begin
							waiting_q <= 1'b0;
						end else if (!full) begin
							count_q <= count_q + 1'b1;
							if (cmd.at_back) begin
								back_q <= back_next;
							end else begin
								front_q <= front_prev;
							end
						end
					end
					dbq_pkg::KIND_POP: begin
						if (!empty) begin
							state_q <= BK_READ;
							count_q <= count_q - 1'b1;
							if (cmd.at_back) begin
								back_q <= back_prev;
							end else begin
								front_q <= front_next;
							end
						end else if (!woken_q) begin
							// a second waiter is ignored, the first one stays
							waiting_q <= 1'b1;
						end
					end
					dbq_pkg::KIND_FLUSH: begin
						count_q <= '0;
						front_q <= '0;
						back_q  <= '0;
					end
					dbq_pkg::KIND_WAKE: begin
						if (empty) begin
							woken_q <= 1'b1;
						end
						waiting_q <= 1'b0;
					end
					default: begin
						state_q <= BK_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* rtl/blocking_double_ended_queue.sv */
// Blocking double-ended queue of 64 words held as a ring in one ram. The front part
// sorts each item into a command and places it in a two-entry queue; the back part
// executes commands one at a time. A pop that removes a stored word also passes through
// the read state of the back part, since the ring ram returns its read data from a
// register; push, count, flush and wake do not. A pop that waits or a wake with no
// waiter gives no result; an unused code is taken by the front part whenever the
// command queue has room and never reaches the back part. Results leave through an
// output register; while a result waits there unread the back part holds, and the
// command queue lets the input take up to two more items before it stalls.
// Depends on dbq_pkg, dbq_front, dbq_cmd_fifo, dbq_back and dbq_ram.
`timescale 1ns / 1ps

module blocking_double_ended_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dbq_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output dbq_pkg::out_item_t out_item
);

	logic          fr_valid;
	logic          fr_ready;
	dbq_pkg::cmd_t fr_cmd;
	logic          bk_valid;
	logic          bk_ready;
	dbq_pkg::cmd_t bk_cmd;

	dbq_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	dbq_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_cmd   (fr_cmd),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_cmd   (bk_cmd)
	);

	dbq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd       (bk_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

/* rtl/dbq_checker.sv */
// port-level checks on the blocking double-ended queue, bound to the top level
// depends on dbq_pkg
`timescale 1ns / 1ps

module dbq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input dbq_pkg::out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped or changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.entry_count <= dbq_pkg::EC_W'(dbq_pkg::DEPTH))
		else $error("entry count above depth");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == dbq_pkg::STAT_FLUSHED |-> out_item.entry_count == '0)
		else $error("flush left entries");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == dbq_pkg::STAT_FULL_DROPPED
		|-> out_item.entry_count == dbq_pkg::EC_W'(dbq_pkg::DEPTH))
		else $error("drop reported while not full");

	a_null_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != dbq_pkg::STAT_POPPED |-> out_item.value_out == '0)
		else $error("value on a result that pops nothing");

endmodule

bind blocking_double_ended_queue dbq_checker u_dbq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

/* tb/sv/blocking_double_ended_queue_tb.sv */
// testbench for blocking_double_ended_queue: a queue-fed driver and a checking monitor
// predicts every result with its own deque model; needs dbq_pkg and the block's rtl
`timescale 1ns / 1ps

module blocking_double_ended_queue_tb;

	localparam logic [dbq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int N_ITEMS = 900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 400;

	typedef struct {
		dbq_pkg::in_item_t item;
		bit                drain;
		int                phase;
	} stim_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	dbq_pkg::in_item_t  in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	dbq_pkg::out_item_t out_item;

	stim_t              stim_items[$];
	dbq_pkg::out_item_t due_results[$];
	int                 n_predicted = 0;
	int                 n_checked = 0;
	int                 n_errors = 0;
	int                 cycles = 0;
	int                 rx_phase = 0;
	int                 hold_left = 0;
	bit                 hold_done = 1'b0;

	int unsigned tx_idle[3] = '{31, 63, 0};
	int unsigned rx_idle[3] = '{63, 31, 0};

	// deque model state
	logic [dbq_pkg::DATA_W-1:0] dq_ring[dbq_pkg::DEPTH];
	logic [dbq_pkg::ADDR_W-1:0] dq_head = '0;
	logic [dbq_pkg::ADDR_W-1:0] dq_tail = '0;
	logic [dbq_pkg::CNT_W-1:0]  dq_fill = '0;
	bit                         dq_woken = 1'b0;
	bit                         dq_waiting = 1'b0;

	blocking_double_ended_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dbq_pkg::out_item_t make_result(logic [dbq_pkg::VAL_W-1:0] v,
		logic [dbq_pkg::ST_W-1:0] st);
		dbq_pkg::out_item_t r;
		r.value_out = v;
		r.status = st;
		r.entry_count = dbq_pkg::EC_W'(dq_fill);
		return r;
	endfunction

	function automatic void deque_step(input dbq_pkg::in_item_t it, output bit has,
		output dbq_pkg::out_item_t r);
		logic [dbq_pkg::DATA_W-1:0] w;
		w = dbq_pkg::DATA_W'(it.item_value);
		has = 1'b0;
		r = '0;
		case (it.operation)
			dbq_pkg::OP_PUSH_FRONT, dbq_pkg::OP_PUSH_BACK: begin
				dq_woken = 1'b0;
				has = 1'b1;
				if (dq_waiting) begin
					// word goes straight to the blocked pop
					dq_waiting = 1'b0;
					r = make_result(dbq_pkg::VAL_W'(w), dbq_pkg::STAT_POPPED);
				end else if (dq_fill >= dbq_pkg::CNT_W'(dbq_pkg::DEPTH)) begin
					r = make_result('0, dbq_pkg::STAT_FULL_DROPPED);
				end else begin
					if (it.operation == dbq_pkg::OP_PUSH_FRONT) begin
						dq_head = (dq_head == '0) ?
							dbq_pkg::ADDR_W'(dbq_pkg::DEPTH - 1) : dq_head - 1'b1;
						dq_ring[dq_head] = w;
					end else begin
						dq_ring[dq_tail] = w;
						dq_tail = (dq_tail == dbq_pkg::ADDR_W'(dbq_pkg::DEPTH - 1)) ?
							'0 : dq_tail + 1'b1;
					end
					dq_fill = dq_fill + 1'b1;
					r = make_result('0, dbq_pkg::STAT_PUSHED);
				end
			end
			dbq_pkg::OP_POP_FRONT, dbq_pkg::OP_POP_BACK: begin
				if (dq_fill != '0) begin
					if (it.operation == dbq_pkg::OP_POP_FRONT) begin
						w = dq_ring[dq_head];
						dq_head = (dq_head == dbq_pkg::ADDR_W'(dbq_pkg::DEPTH - 1)) ?
							'0 : dq_head + 1'b1;
					end else begin
						dq_tail = (dq_tail == '0) ?
							dbq_pkg::ADDR_W'(dbq_pkg::DEPTH - 1) : dq_tail - 1'b1;
						w = dq_ring[dq_tail];
					end
					dq_fill = dq_fill - 1'b1;
					has = 1'b1;
					r = make_result(dbq_pkg::VAL_W'(w), dbq_pkg::STAT_POPPED);
				end else if (dq_woken) begin
					has = 1'b1;
					r = make_result('0, dbq_pkg::STAT_WOKEN_NULL);
				end else begin
					// blocks; a second pop while one waits is dropped
					dq_waiting = 1'b1;
				end
			end
			dbq_pkg::OP_COUNT: begin
				has = 1'b1;
				r = make_result('0, dbq_pkg::STAT_COUNT);
			end
			dbq_pkg::OP_FLUSH: begin
				dq_fill = '0;
				dq_head = '0;
				dq_tail = '0;
				has = 1'b1;
				r = make_result('0, dbq_pkg::STAT_FLUSHED);
			end
			dbq_pkg::OP_WAKE: begin
				if (dq_fill == '0)
					dq_woken = 1'b1;
				if (dq_waiting) begin
					dq_waiting = 1'b0;
					has = 1'b1;
					r = make_result('0, dbq_pkg::STAT_WOKEN_NULL);
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic flag_mismatch(string what, logic [dbq_pkg::VAL_W-1:0] got,
		logic [dbq_pkg::VAL_W-1:0] want);
		if (n_errors < 100)
			$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
		n_errors++;
	endtask

	function automatic void add_op(logic [dbq_pkg::OP_W-1:0] op,
		logic [dbq_pkg::VAL_W-1:0] v, bit drain = 1'b0);
		stim_t s;
		s.item.operation = op;
		s.item.item_value = v;
		s.drain = drain;
		s.phase = (stim_items.size() < N_ITEMS / 3) ? 0 :
			(stim_items.size() < 2 * N_ITEMS / 3) ? 1 : 2;
		stim_items.push_back(s);
	endfunction

	function automatic logic [dbq_pkg::VAL_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [dbq_pkg::OP_W-1:0] rand_push();
		return $urandom_range(0, 1) ? dbq_pkg::OP_PUSH_BACK : dbq_pkg::OP_PUSH_FRONT;
	endfunction

	function automatic logic [dbq_pkg::OP_W-1:0] rand_pop();
		return $urandom_range(0, 1) ? dbq_pkg::OP_POP_BACK : dbq_pkg::OP_POP_FRONT;
	endfunction

	function automatic logic [dbq_pkg::OP_W-1:0] rand_any_op();
		return dbq_pkg::OP_W'($urandom_range(dbq_pkg::OP_PUSH_FRONT, OP_UNUSED));
	endfunction

	// driver: holds an item until taken, then offers the next one
	always @(posedge clk) begin : driver
		bit                 taken;
		bit                 go;
		bit                 has;
		dbq_pkg::out_item_t r;
		stim_t              s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			taken = in_valid && in_ready;
			if (taken) begin
				deque_step(in_item, has, r);
				if (has) begin
					due_results.push_back(r);
					n_predicted <= n_predicted + 1;
				end
			end
			if (!in_valid || taken) begin
				go = 1'b0;
				if (stim_items.size() != 0) begin
					if (stim_items[0].drain)
						go = !in_valid && (n_predicted == n_checked);
					else
						go = $urandom_range(0, 99) >= tx_idle[stim_items[0].phase];
				end
				if (go) begin
					s = stim_items.pop_front();
					in_item <= s.item;
					rx_phase <= s.phase;
				end
				in_valid <= go;
			end
		end
	end

	// one long receiver hold-off, counted in cycles
	always @(posedge clk) begin : hold_off
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (!hold_done && n_checked >= HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
			end
		end
	end

	// monitor: checks each taken result and randomizes ready
	always @(posedge clk) begin : monitor
		dbq_pkg::out_item_t want;
		bit                 rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					flag_mismatch("result with nothing due", out_item.value_out, '0);
				end else begin
					want = due_results.pop_front();
					if (out_item.value_out !== want.value_out)
						flag_mismatch("value_out", out_item.value_out, want.value_out);
					if (out_item.status !== want.status)
						flag_mismatch("status", dbq_pkg::VAL_W'(out_item.status),
							dbq_pkg::VAL_W'(want.status));
					if (out_item.entry_count !== want.entry_count)
						flag_mismatch("entry_count", dbq_pkg::VAL_W'(out_item.entry_count),
							dbq_pkg::VAL_W'(want.entry_count));
				end
				n_checked <= n_checked + 1;
			end
			if (hold_left != 0)
				rdy = 1'b0;
			else
				rdy = $urandom_range(0, 99) >= rx_idle[rx_phase];
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[blocking_double_ended_queue] ERROR");
			$finish;
		end
	end

	initial begin
		int kind;
		int len;
		int bias;
		bit drain;

		// directed: blocking pop, wake, flush keeping the mark, unused code
		add_op(dbq_pkg::OP_COUNT, '0);
		add_op(dbq_pkg::OP_POP_FRONT, '0);
		add_op(dbq_pkg::OP_POP_BACK, '0);
		add_op(dbq_pkg::OP_PUSH_BACK, '1);
		add_op(dbq_pkg::OP_WAKE, '0);
		add_op(dbq_pkg::OP_POP_BACK, '0);
		add_op(dbq_pkg::OP_PUSH_FRONT, '0);
		add_op(dbq_pkg::OP_PUSH_BACK, 32'ha5a5_5a5a);
		add_op(dbq_pkg::OP_PUSH_FRONT, 32'h8000_0001);
		add_op(dbq_pkg::OP_WAKE, '0);
		add_op(dbq_pkg::OP_POP_BACK, '0);
		add_op(dbq_pkg::OP_POP_FRONT, '0);
		add_op(OP_UNUSED, '1);
		add_op(dbq_pkg::OP_COUNT, 32'h1234_5678);
		add_op(dbq_pkg::OP_FLUSH, '0);
		add_op(dbq_pkg::OP_POP_FRONT, '0);
		add_op(dbq_pkg::OP_WAKE, '0);
		add_op(dbq_pkg::OP_FLUSH, '0);
		add_op(dbq_pkg::OP_POP_FRONT, '0);
		add_op(dbq_pkg::OP_PUSH_BACK, 32'h5555_5555);
		add_op(dbq_pkg::OP_POP_FRONT, '0);

		// fill past the top so a push gets dropped, after a full drain
		add_op(dbq_pkg::OP_FLUSH, '0, 1'b1);
		repeat (dbq_pkg::DEPTH + 6) add_op(rand_push(), rand_word());
		repeat (10) add_op(rand_pop(), rand_word());

		while (stim_items.size() < N_ITEMS) begin
			kind = $urandom_range(0, 9);
			drain = ($urandom_range(0, 11) == 0);
			bias = (kind < 4) ? 65 : 30;
			case (kind)
				0, 1, 2, 3, 4, 5: begin
					len = $urandom_range(5, 40);
					add_op(rand_push(), rand_word(), drain);
					repeat (len) begin
						if ($urandom_range(0, 99) < bias)
							add_op(rand_push(), rand_word());
						else
							add_op(rand_pop(), rand_word());
					end
				end
				6: begin
					add_op(dbq_pkg::OP_FLUSH, rand_word(), drain);
					repeat (dbq_pkg::DEPTH + $urandom_range(0, 4))
						add_op(rand_push(), rand_word());
					repeat ($urandom_range(1, 8)) add_op(rand_pop(), rand_word());
				end
				7: begin
					// push clears the mark, so the pop after the flush blocks
					add_op(rand_push(), rand_word(), drain);
					add_op(dbq_pkg::OP_FLUSH, rand_word());
					add_op(rand_pop(), rand_word());
					if ($urandom_range(0, 1))
						add_op(rand_pop(), rand_word());
					if ($urandom_range(0, 1))
						add_op(dbq_pkg::OP_COUNT, rand_word());
					if ($urandom_range(0, 1))
						add_op(rand_push(), rand_word());
					else
						add_op(dbq_pkg::OP_WAKE, rand_word());
				end
				8: begin
					add_op(dbq_pkg::OP_FLUSH, rand_word(), drain);
					add_op(dbq_pkg::OP_WAKE, rand_word());
					add_op(rand_pop(), rand_word());
					add_op(dbq_pkg::OP_FLUSH, rand_word());
					add_op(rand_pop(), rand_word());
					add_op(rand_push(), rand_word());
				end
				default: begin
					add_op(rand_any_op(), rand_word(), drain);
					repeat ($urandom_range(3, 10))
						add_op(rand_any_op(), rand_word());
				end
			endcase
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (stim_items.size() == 0 && !in_valid);
		wait (n_checked == n_predicted);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_results.size() != 0)
			flag_mismatch("results never arrived", dbq_pkg::VAL_W'(due_results.size()), '0);

		if (n_errors == 0)
			$display("[blocking_double_ended_queue] OK");
		else
			$display("[blocking_double_ended_queue] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/dbq_pkg.sv
rtl/dbq_ram.sv
rtl/dbq_cmd_fifo.sv
rtl/dbq_front.sv
rtl/dbq_back.sv
rtl/blocking_double_ended_queue.sv
rtl/dbq_checker.sv
tb/sv/blocking_double_ended_queue_tb.sv
